>>> src/b64d_pkg.sv
`timescale 1ns / 1ps
package b64d_pkg;

    localparam int MAX_OUTPUT_BYTES = 4096;

    localparam int CHAR_W  = 8;
    localparam int SEXT_W  = 6;
    localparam int COUNT_W = 13;
    localparam int TDATA_W = 40;
    localparam int TUSER_W = 2;
    localparam int ADDR_W  = 3;

    localparam logic [COUNT_W-1:0] LIMIT_RESET = COUNT_W'(4096);
    localparam logic [COUNT_W-1:0] LIMIT_CAP   = COUNT_W'(MAX_OUTPUT_BYTES);

    // Register index taken from the word address bits of paddr.
    localparam logic REG_OUTPUT_LIMIT = 1'b0;

    localparam logic [CHAR_W-1:0] PAD_CHAR = 8'h3D;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              end_of_text;
    } t_char_beat;

    typedef struct packed {
        logic [COUNT_W-1:0] total_bytes;
        logic               end_of_stream;
        logic               incomplete_group;
        logic               bad_character;
        logic [1:0]         byte_count;
        logic [7:0]         byte_third;
        logic [7:0]         byte_second;
        logic [7:0]         byte_first;
    } t_result;

    // Sextet of an alphabet character in bits 5:0; bit 6 set for anything else.
    function automatic logic [SEXT_W:0] map_char(input logic [CHAR_W-1:0] c);
        logic [SEXT_W:0] s;
        priority if (c >= 8'h41 && c <= 8'h5A) begin
            s = 7'(c - 8'h41);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            s = 7'(c - 8'h61 + 8'd26);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            s = 7'(c - 8'h30 + 8'd52);
        end else if (c == 8'h2B) begin
            s = 7'd62;
        end else if (c == 8'h2F) begin
            s = 7'd63;
        end else begin
            s = 7'd64;
        end
        return s;
    endfunction

endpackage

>>> src/b64d_in_reg.sv
`timescale 1ns / 1ps
module b64d_in_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  b64d_pkg::t_char_beat i_beat,
    output logic                o_valid,
    input  logic                i_advance,
    output b64d_pkg::t_char_beat o_beat
);
    import b64d_pkg::*;

    logic       r_valid;
    t_char_beat r_beat;

    // The slot frees up in the same cycle that the group stage takes its beat.
    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_beat  = r_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_beat <= i_beat;
        end
    end

endmodule

>>> src/b64d_group.sv
`timescale 1ns / 1ps
module b64d_group (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  b64d_pkg::t_char_beat        i_beat,
    input  logic [b64d_pkg::COUNT_W-1:0] i_limit,
    input  logic                       i_out_free,
    output logic                       o_advance,
    output logic                       o_load,
    output b64d_pkg::t_result           o_result
);
    import b64d_pkg::*;

    logic [1:0]         r_pos;
    logic [17:0]        r_store;
    logic [1:0]         r_pads;
    logic [COUNT_W-1:0] r_kept;
    logic               r_bad;

    logic [1:0]         n_pos;
    logic [17:0]        n_store;
    logic [1:0]         n_pads;
    logic [COUNT_W-1:0] n_kept;
    logic               n_bad;

    logic [SEXT_W:0]    mapped;
    logic               is_pad;
    logic               bad_now;
    logic [SEXT_W-1:0]  sext;
    logic [23:0]        triple;
    logic               has_result;
    logic [COUNT_W-1:0] lim;
    logic [COUNT_W:0]   kept_x;
    logic               ok0;
    logic               ok1;
    logic               ok2;
    logic               pad3;
    logic [1:0]         cnt;

    assign is_pad  = (i_beat.char_code == PAD_CHAR);
    assign mapped  = map_char(i_beat.char_code);
    assign bad_now = !is_pad && mapped[SEXT_W];
    assign sext    = (is_pad || mapped[SEXT_W]) ? '0 : mapped[SEXT_W-1:0];
    assign triple  = {r_store, sext};
    assign lim     = (i_limit > LIMIT_CAP) ? LIMIT_CAP : i_limit;
    assign kept_x  = {1'b0, r_kept};
    assign pad3    = is_pad || r_pads[1];

    // Each byte needs room under the limit after all bytes kept so far, this group's included.
    assign ok0 = kept_x < {1'b0, lim};
    assign ok1 = !r_pads[0] && ((kept_x + (COUNT_W+1)'(ok0)) < {1'b0, lim});
    assign ok2 = !pad3 &&
                 ((kept_x + (COUNT_W+1)'(ok0) + (COUNT_W+1)'(ok1)) < {1'b0, lim});
    assign cnt = 2'(ok0) + 2'(ok1) + 2'(ok2);

    assign has_result = (r_pos == 2'd3) || i_beat.end_of_text;
    assign o_advance  = i_valid && (!has_result || i_out_free);
    assign o_load     = o_advance && has_result;

    always_comb begin
        n_bad   = r_bad | bad_now;
        n_pos   = r_pos + 2'd1;
        n_store = {r_store[11:0], sext};
        n_pads  = r_pads;
        n_kept  = r_kept;

        o_result                  = '0;
        o_result.end_of_stream    = i_beat.end_of_text;
        o_result.bad_character    = n_bad;

        if (r_pos != 2'd3) begin
            if (r_pos == 2'd2 && is_pad) begin
                n_pads[0] = 1'b1;
            end
            o_result.incomplete_group = 1'b1;
        end else begin
            n_pos   = '0;
            n_store = '0;
            n_pads  = '0;
            n_kept  = r_kept + COUNT_W'(cnt);
            o_result.byte_first  = ok0 ? triple[23:16] : 8'h00;
            o_result.byte_second = ok1 ? triple[15:8] : (ok2 ? triple[7:0] : 8'h00);
            o_result.byte_third  = (ok1 && ok2) ? triple[7:0] : 8'h00;
            o_result.byte_count  = cnt;
        end
        o_result.total_bytes = n_kept;

        if (i_beat.end_of_text) begin
            n_pos   = '0;
            n_store = '0;
            n_pads  = '0;
            n_kept  = '0;
            n_bad   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_store <= '0;
            r_pads  <= '0;
            r_kept  <= '0;
            r_bad   <= 1'b0;
        end else if (o_advance) begin
            r_pos   <= n_pos;
            r_store <= n_store;
            r_pads  <= n_pads;
            r_kept  <= n_kept;
            r_bad   <= n_bad;
        end
    end

endmodule

>>> src/b64d_out_reg.sv
`timescale 1ns / 1ps
module b64d_out_reg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_load,
    input  b64d_pkg::t_result                 i_result,
    output logic                             o_free,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [b64d_pkg::TDATA_W-1:0]      o_tdata,
    output logic [b64d_pkg::TUSER_W-1:0]      o_tuser,
    output logic                             o_tlast
);
    import b64d_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_tdata = {1'b0, r_res.total_bytes, r_res.byte_count,
                      r_res.byte_third, r_res.byte_second, r_res.byte_first};
    assign o_tuser = {r_res.incomplete_group, r_res.bad_character};
    assign o_tlast = r_res.end_of_stream;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_result;
        end
    end

endmodule

>>> src/base64_decoder_top.sv
`timescale 1ns / 1ps
// Base64 text decoder (standard alphabet, '=' padding).
// Slave stream: one text character per beat in s_axis_tdata, s_axis_tlast on
// the last character of a stream. Master stream: one beat per fourth
// character of a group and one for the last character of a stream, with up
// to three decoded bytes, their count and the running kept total; tuser
// carries the sticky bad-character flag and the partial-group flag.
// An accepted character is held in the input register; the group logic loads
// its result into the result register. One character is taken every cycle
// while the master side does not stall: the input and result registers each
// hold one beat, and the whole decode of a character is a table look-up and an
// 18-bit shift. The result register frees in the cycle it is read and the
// ready path is combinational, so a master-side stall reaches s_axis_tready at
// once; characters that give no result still move on while a result waits.
// Reset clears the group state, the kept count, the flags and both valid
// registers, and sets output_limit (APB, byte address 0) to 4096.
module base64_decoder_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [b64d_pkg::CHAR_W-1:0]      s_axis_tdata,   // [7:0] char_code
    input  logic                            s_axis_tlast,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [7:0] byte_first, [15:8] byte_second, [23:16] byte_third,
    // [25:24] byte_count, [38:26] total_bytes, [39] zero
    output logic [b64d_pkg::TDATA_W-1:0]     m_axis_tdata,
    // [0] bad_character, [1] incomplete_group
    output logic [b64d_pkg::TUSER_W-1:0]     m_axis_tuser,
    output logic                            m_axis_tlast,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [b64d_pkg::ADDR_W-1:0]      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import b64d_pkg::*;

    logic [COUNT_W-1:0] r_limit;
    t_char_beat         in_beat;
    t_char_beat         held_beat;
    t_result            result;
    logic               held_valid;
    logic               advance;
    logic               load;
    logic               out_free;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_OUTPUT_LIMIT) ? {19'd0, r_limit} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_OUTPUT_LIMIT) begin
            r_limit <= pwdata[COUNT_W-1:0];
        end
    end

    assign in_beat.char_code   = s_axis_tdata;
    assign in_beat.end_of_text = s_axis_tlast;

    b64d_in_reg u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_beat    (in_beat),
        .o_valid   (held_valid),
        .i_advance (advance),
        .o_beat    (held_beat)
    );

    b64d_group u_group (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (held_valid),
        .i_beat     (held_beat),
        .i_limit    (r_limit),
        .i_out_free (out_free),
        .o_advance  (advance),
        .o_load     (load),
        .o_result   (result)
    );

    b64d_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (load),
        .i_result (result),
        .o_free   (out_free),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tuser  (m_axis_tuser),
        .o_tlast  (m_axis_tlast)
    );

endmodule

>>> src/b64d_checker.sv
`timescale 1ns / 1ps
module b64d_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        m_axis_tvalid,
    input logic                        m_axis_tready,
    input logic [b64d_pkg::TDATA_W-1:0] m_axis_tdata,
    input logic [b64d_pkg::TUSER_W-1:0] m_axis_tuser,
    input logic                        m_axis_tlast
);
    import b64d_pkg::*;

    // A stalled result beat holds its contents.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result beat changed while stalled");

    // Nothing leaves the block in the cycle after reset.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result beat valid after reset");

    // A partial group only closes a stream and carries no bytes.
    a_partial: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |->
            m_axis_tlast && m_axis_tdata[25:0] == 26'd0)
        else $error("partial group beat carries bytes or is not last");

    // The third byte slot is zero unless the count is three.
    a_slots: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[25:24] != 2'd3 |-> m_axis_tdata[23:16] == 8'h00)
        else $error("unused third byte slot not zero");

    // The kept total never exceeds the build-time cap.
    a_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[38:26] <= LIMIT_CAP)
        else $error("kept total above cap");

endmodule

bind base64_decoder_top b64d_checker u_b64d_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
